### sv/obve_pkg.sv
// ----------------------------------------------------------------------------
// obve_pkg: shared types and constants of the body velocity estimator
// Field widths, arithmetic widths, CORDIC constants and payload structs.
// ----------------------------------------------------------------------------
package obve_pkg;

    localparam int TIME_W        = 48;
    localparam int POS_W         = 32;
    localparam int ANG_W         = 16;
    localparam int OUT_W         = 32;

    localparam int DPOS_W        = POS_W + 1;
    localparam int CORDIC_W      = 34;
    localparam int CORDIC_STEPS  = 24;
    localparam int STEP_W        = $clog2(CORDIC_STEPS);
    localparam int Q_FRAC        = 30;
    localparam int FIX_W         = POS_W + 3;
    localparam int MUL_A_W       = FIX_W;
    localparam int MUL_B_W       = 32;
    localparam int PROD_W        = MUL_A_W + MUL_B_W;
    localparam int NUM_W         = PROD_W + 16;
    localparam int DEN_W         = TIME_W + ANG_W;

    localparam logic signed [CORDIC_W-1:0] CORDIC_K = 34'sh0_26DD_3B6A;
    localparam logic [MUL_B_W-1:0] US_PER_S  = 32'd1000000;
    localparam logic [MUL_B_W-1:0] TWO_PI_E6 = 32'd6283185;

    typedef struct packed {
        logic        [TIME_W-1:0] sample_time_us;
        logic signed [POS_W-1:0]  position_x;
        logic signed [POS_W-1:0]  position_y;
        logic        [ANG_W-1:0]  heading;
    } t_sample;

    typedef struct packed {
        logic signed [OUT_W-1:0] vel_x;
        logic signed [OUT_W-1:0] vel_y;
        logic signed [OUT_W-1:0] yaw_rate;
    } t_result;

    function automatic logic [31:0] cordic_atan(input logic [STEP_W-1:0] idx);
        logic [31:0] v;
        unique case (idx)
            5'd0:  v = 32'h2000_0000;
            5'd1:  v = 32'h12E4_051E;
            5'd2:  v = 32'h09FB_385B;
            5'd3:  v = 32'h0511_11D4;
            5'd4:  v = 32'h028B_0D43;
            5'd5:  v = 32'h0145_D7E1;
            5'd6:  v = 32'h00A2_F61E;
            5'd7:  v = 32'h0051_7C55;
            5'd8:  v = 32'h0028_BE53;
            5'd9:  v = 32'h0014_5F2F;
            5'd10: v = 32'h000A_2F98;
            5'd11: v = 32'h0005_17CC;
            5'd12: v = 32'h0002_8BE6;
            5'd13: v = 32'h0001_45F3;
            5'd14: v = 32'h0000_A2FA;
            5'd15: v = 32'h0000_517D;
            5'd16: v = 32'h0000_28BE;
            5'd17: v = 32'h0000_145F;
            5'd18: v = 32'h0000_0A30;
            5'd19: v = 32'h0000_0518;
            5'd20: v = 32'h0000_028C;
            5'd21: v = 32'h0000_0146;
            5'd22: v = 32'h0000_00A3;
            5'd23: v = 32'h0000_0051;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

endpackage

### sv/odometry_body_velocity_estimator_unit.sv
// ----------------------------------------------------------------------------
// odometry_body_velocity_estimator_unit: body-frame velocity from pose steps
// Sequence per request: the CORDIC, seven serial multiplies, three serial divides,
// then the load of the output register. The input is stalled from the start of a
// computation until its result is loaded, and longer while a finished result waits
// on output stall. First and non-advancing requests are taken without starting the
// sequencer. Reset (synchronous, active low) clears the stored sample flag and sequencer.
// ----------------------------------------------------------------------------
module odometry_body_velocity_estimator_unit
    import obve_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_sample i_in,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_result o_out
);

    // Sequencer states
    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_CORDIC = 5'b00010,
        ST_MUL    = 5'b00100,
        ST_DIV    = 5'b01000,
        ST_DONE   = 5'b10000
    } t_state;

    // Multiply steps: four rotation products, then the three numerators
    localparam logic [2:0] OP_DX_COS  = 3'd0;
    localparam logic [2:0] OP_DY_SIN  = 3'd1;
    localparam logic [2:0] OP_DY_COS  = 3'd2;
    localparam logic [2:0] OP_DX_SIN  = 3'd3;
    localparam logic [2:0] OP_NUM_X   = 3'd4;
    localparam logic [2:0] OP_NUM_Y   = 3'd5;
    localparam logic [2:0] OP_NUM_YAW = 3'd6;
    // Divide steps
    localparam logic [1:0] DV_X   = 2'd0;
    localparam logic [1:0] DV_Y   = 2'd1;
    localparam logic [1:0] DV_YAW = 2'd2;

    t_state r_state, n_state;

    logic                       r_have, n_have;
    logic [TIME_W-1:0]          r_prev_t, n_prev_t;
    logic signed [POS_W-1:0]    r_prev_x, n_prev_x, r_prev_y, n_prev_y;
    logic [ANG_W-1:0]           r_prev_h, n_prev_h;
    logic [TIME_W-1:0]          r_dt, n_dt;
    logic signed [DPOS_W-1:0]   r_dx, n_dx, r_dy, n_dy;
    logic signed [ANG_W-1:0]    r_dyaw, n_dyaw;
    logic signed [CORDIC_W-1:0] r_cos, n_cos, r_sin, n_sin;
    logic signed [FIX_W-1:0]    r_fx, n_fx, r_fy, n_fy;
    logic [NUM_W-1:0]           r_num_x, n_num_x, r_num_y, n_num_y, r_num_yaw, n_num_yaw;
    logic [2:0]                 r_op, n_op;
    logic [1:0]                 r_dv, n_dv;
    logic                       r_mul_go, n_mul_go, r_div_go, n_div_go, r_cor_go, n_cor_go;
    logic [OUT_W-1:0]           r_vx, n_vx, r_vy, n_vy, r_yr, n_yr;
    t_result                    r_out, n_out;
    logic                       r_out_valid, n_out_valid;

    logic                       w_in_acc;
    logic                       w_cor_done, w_mul_done, w_div_done;
    logic signed [CORDIC_W-1:0] w_cos, w_sin;
    logic [MUL_A_W-1:0]         w_mul_a;
    logic [MUL_B_W-1:0]         w_mul_b;
    logic [PROD_W-1:0]          w_prod;
    logic [NUM_W-1:0]           w_div_num, w_quo;
    logic [DEN_W-1:0]           w_div_den;
    logic [PROD_W-Q_FRAC-1:0]   w_prod_hi;
    logic [FIX_W-1:0]           w_tmag;
    logic signed [FIX_W-1:0]    w_t;
    logic                       w_tneg;
    logic signed [DPOS_W-1:0]   w_dx_new, w_dy_new;

    // Magnitude helpers, all unsigned results
    function automatic logic [MUL_A_W-1:0] abs_pos(input logic signed [DPOS_W-1:0] v);
        logic [DPOS_W-1:0] m;
        m = v[DPOS_W-1] ? DPOS_W'(-v) : DPOS_W'(v);
        return MUL_A_W'(m);
    endfunction

    function automatic logic [MUL_B_W-1:0] abs_cor(input logic signed [CORDIC_W-1:0] v);
        logic [CORDIC_W-1:0] m;
        m = v[CORDIC_W-1] ? CORDIC_W'(-v) : CORDIC_W'(v);
        return m[MUL_B_W-1:0];
    endfunction

    function automatic logic [MUL_A_W-1:0] abs_fix(input logic signed [FIX_W-1:0] v);
        return v[FIX_W-1] ? MUL_A_W'(-v) : MUL_A_W'(v);
    endfunction

    function automatic logic [MUL_A_W-1:0] abs_ang(input logic signed [ANG_W-1:0] v);
        logic [ANG_W-1:0] m;
        m = v[ANG_W-1] ? ANG_W'(-v) : ANG_W'(v);
        return MUL_A_W'(m);
    endfunction

    // Clamp a sign and magnitude to the signed 32-bit range
    function automatic logic [OUT_W-1:0] sat_out(input logic neg, input logic [NUM_W-1:0] q);
        logic big;
        big = |q[NUM_W-1:OUT_W-1];
        if (neg) begin
            return big ? {1'b1, {(OUT_W-1){1'b0}}} : -q[OUT_W-1:0];
        end
        return big ? {1'b0, {(OUT_W-1){1'b1}}} : q[OUT_W-1:0];
    endfunction

    assign o_in_stall = (r_state != ST_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;

    // Shared arithmetic units
    obve_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_cor_go),
        .i_angle (r_prev_h),
        .o_done  (w_cor_done),
        .o_cos   (w_cos),
        .o_sin   (w_sin)
    );

    obve_mul #(.A_W(MUL_A_W), .B_W(MUL_B_W)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mul_go),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    obve_div #(.N_W(NUM_W), .D_W(DEN_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_go),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    // Select the operands of the current multiply step
    always_comb begin
        unique case (r_op)
            OP_DX_COS: begin
                w_mul_a = abs_pos(r_dx);
                w_mul_b = abs_cor(r_cos);
                w_tneg  = r_dx[DPOS_W-1] ^ r_cos[CORDIC_W-1];
            end
            OP_DY_SIN: begin
                w_mul_a = abs_pos(r_dy);
                w_mul_b = abs_cor(r_sin);
                w_tneg  = r_dy[DPOS_W-1] ^ r_sin[CORDIC_W-1];
            end
            OP_DY_COS: begin
                w_mul_a = abs_pos(r_dy);
                w_mul_b = abs_cor(r_cos);
                w_tneg  = r_dy[DPOS_W-1] ^ r_cos[CORDIC_W-1];
            end
            OP_DX_SIN: begin
                w_mul_a = abs_pos(r_dx);
                w_mul_b = abs_cor(r_sin);
                w_tneg  = r_dx[DPOS_W-1] ^ r_sin[CORDIC_W-1];
            end
            OP_NUM_X: begin
                w_mul_a = abs_fix(r_fx);
                w_mul_b = US_PER_S;
                w_tneg  = 1'b0;
            end
            OP_NUM_Y: begin
                w_mul_a = abs_fix(r_fy);
                w_mul_b = US_PER_S;
                w_tneg  = 1'b0;
            end
            OP_NUM_YAW: begin
                w_mul_a = abs_ang(r_dyaw);
                w_mul_b = TWO_PI_E6;
                w_tneg  = 1'b0;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
                w_tneg  = 1'b0;
            end
        endcase
    end

    // Select the operands of the current divide step; yaw divides by dt * 2^ANG_W
    always_comb begin
        unique case (r_dv)
            DV_X: begin
                w_div_num = r_num_x;
                w_div_den = DEN_W'(r_dt);
            end
            DV_Y: begin
                w_div_num = r_num_y;
                w_div_den = DEN_W'(r_dt);
            end
            DV_YAW: begin
                w_div_num = r_num_yaw;
                w_div_den = {r_dt, {ANG_W{1'b0}}};
            end
            default: begin
                w_div_num = '0;
                w_div_den = '1;
            end
        endcase
    end

    // Truncate the rotation product toward zero: floor of the magnitude, then sign
    assign w_prod_hi = w_prod[PROD_W-1:Q_FRAC];
    assign w_tmag    = w_prod_hi[FIX_W-1:0];
    assign w_t       = w_tneg ? -signed'(w_tmag) : signed'(w_tmag);

    assign w_dx_new  = DPOS_W'(i_in.position_x) - DPOS_W'(r_prev_x);
    assign w_dy_new  = DPOS_W'(i_in.position_y) - DPOS_W'(r_prev_y);

    always_comb begin
        n_state     = r_state;
        n_have      = r_have;
        n_prev_t    = r_prev_t;
        n_prev_x    = r_prev_x;
        n_prev_y    = r_prev_y;
        n_prev_h    = r_prev_h;
        n_dt        = r_dt;
        n_dx        = r_dx;
        n_dy        = r_dy;
        n_dyaw      = r_dyaw;
        n_cos       = r_cos;
        n_sin       = r_sin;
        n_fx        = r_fx;
        n_fy        = r_fy;
        n_num_x     = r_num_x;
        n_num_y     = r_num_y;
        n_num_yaw   = r_num_yaw;
        n_op        = r_op;
        n_dv        = r_dv;
        n_mul_go    = 1'b0;
        n_div_go    = 1'b0;
        n_cor_go    = 1'b0;
        n_vx        = r_vx;
        n_vy        = r_vy;
        n_yr        = r_yr;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;

        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    priority if (!r_have) begin
                        // First sample: store only
                        n_have   = 1'b1;
                        n_prev_t = i_in.sample_time_us;
                        n_prev_x = i_in.position_x;
                        n_prev_y = i_in.position_y;
                        n_prev_h = i_in.heading;
                    end else if (i_in.sample_time_us > r_prev_t) begin
                        // Capture the steps, then replace the stored sample
                        n_dt     = i_in.sample_time_us - r_prev_t;
                        n_dx     = w_dx_new;
                        n_dy     = w_dy_new;
                        n_dyaw   = signed'(i_in.heading - r_prev_h);
                        n_prev_t = i_in.sample_time_us;
                        n_prev_x = i_in.position_x;
                        n_prev_y = i_in.position_y;
                        n_prev_h = i_in.heading;
                        n_cor_go = 1'b1;
                        n_state  = ST_CORDIC;
                    end else begin
                        // Time not advancing: drop, keep the stored sample
                    end
                end
            end
            ST_CORDIC: begin
                if (w_cor_done) begin
                    n_cos    = w_cos;
                    n_sin    = w_sin;
                    n_op     = OP_DX_COS;
                    n_mul_go = 1'b1;
                    n_state  = ST_MUL;
                end
            end
            ST_MUL: begin
                if (w_mul_done) begin
                    unique case (r_op)
                        OP_DX_COS:  n_fx      = w_t;
                        OP_DY_SIN:  n_fx      = r_fx + w_t;
                        OP_DY_COS:  n_fy      = w_t;
                        OP_DX_SIN:  n_fy      = r_fy - w_t;
                        OP_NUM_X:   n_num_x   = NUM_W'(w_prod);
                        OP_NUM_Y:   n_num_y   = NUM_W'(w_prod);
                        OP_NUM_YAW: n_num_yaw = {w_prod, 16'd0};
                        default:    n_num_yaw = r_num_yaw;
                    endcase
                    if (r_op == OP_NUM_YAW) begin
                        n_dv     = DV_X;
                        n_div_go = 1'b1;
                        n_state  = ST_DIV;
                    end else begin
                        n_op     = r_op + 1'b1;
                        n_mul_go = 1'b1;
                    end
                end
            end
            ST_DIV: begin
                if (w_div_done) begin
                    unique case (r_dv)
                        DV_X:    n_vx = sat_out(r_fx[FIX_W-1], w_quo);
                        DV_Y:    n_vy = sat_out(r_fy[FIX_W-1], w_quo);
                        DV_YAW:  n_yr = sat_out(r_dyaw[ANG_W-1], w_quo);
                        default: n_vx = r_vx;
                    endcase
                    if (r_dv == DV_YAW) begin
                        n_state = ST_DONE;
                    end else begin
                        n_dv     = r_dv + 1'b1;
                        n_div_go = 1'b1;
                    end
                end
            end
            ST_DONE: begin
                // Hold until the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    n_out.vel_x    = r_vx;
                    n_out.vel_y    = r_vy;
                    n_out.yaw_rate = r_yr;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_have      <= 1'b0;
            r_prev_t    <= '0;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_prev_h    <= '0;
            r_op        <= OP_DX_COS;
            r_dv        <= DV_X;
            r_mul_go    <= 1'b0;
            r_div_go    <= 1'b0;
            r_cor_go    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_have      <= n_have;
            r_prev_t    <= n_prev_t;
            r_prev_x    <= n_prev_x;
            r_prev_y    <= n_prev_y;
            r_prev_h    <= n_prev_h;
            r_op        <= n_op;
            r_dv        <= n_dv;
            r_mul_go    <= n_mul_go;
            r_div_go    <= n_div_go;
            r_cor_go    <= n_cor_go;
            r_out_valid <= n_out_valid;
        end
        r_dt      <= n_dt;
        r_dx      <= n_dx;
        r_dy      <= n_dy;
        r_dyaw    <= n_dyaw;
        r_cos     <= n_cos;
        r_sin     <= n_sin;
        r_fx      <= n_fx;
        r_fy      <= n_fy;
        r_num_x   <= n_num_x;
        r_num_y   <= n_num_y;
        r_num_yaw <= n_num_yaw;
        r_vx      <= n_vx;
        r_vy      <= n_vy;
        r_yr      <= n_yr;
        r_out     <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // The first request after reset is stored only, never computed
    a_first_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && !r_have) |=> (r_state == ST_IDLE))
        else $error("first request started a computation");

    // Unit completions arrive only in the state that waits for them
    a_cor_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cor_done |-> (r_state == ST_CORDIC))
        else $error("CORDIC completion outside its state");

    a_mul_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_done |-> (r_state == ST_MUL))
        else $error("multiplier completion outside its state");

    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == ST_DIV))
        else $error("divider completion outside its state");

endmodule

### sv/obve_cordic.sv
// ----------------------------------------------------------------------------
// obve_cordic: iterative CORDIC sine and cosine
// One micro-rotation per cycle; half-turn fold for angles in the rear half.
// ----------------------------------------------------------------------------
module obve_cordic
    import obve_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [ANG_W-1:0]           i_angle,
    output logic                       o_done,
    output logic signed [CORDIC_W-1:0] o_cos,
    output logic signed [CORDIC_W-1:0] o_sin
);

    logic                       r_busy, n_busy;
    logic                       r_done, n_done;
    logic                       r_flip, n_flip;
    logic [STEP_W-1:0]          r_step, n_step;
    logic signed [CORDIC_W-1:0] r_x, n_x, r_y, n_y, r_z, n_z;
    logic [31:0]                w_a, w_a2, w_quad;
    logic signed [CORDIC_W-1:0] w_xs, w_ys, w_atan;

    always_comb begin
        w_a    = {i_angle, {(32-ANG_W){1'b0}}};
        w_quad = w_a + 32'h4000_0000;
        w_a2   = w_quad[31] ? (w_a ^ 32'h8000_0000) : w_a;
        w_xs   = r_x >>> r_step;
        w_ys   = r_y >>> r_step;
        w_atan = signed'({{(CORDIC_W-32){1'b0}}, cordic_atan(r_step)});
        n_busy = r_busy;
        n_done = 1'b0;
        n_flip = r_flip;
        n_step = r_step;
        n_x    = r_x;
        n_y    = r_y;
        n_z    = r_z;
        if (i_start) begin
            n_busy = 1'b1;
            n_flip = w_quad[31];
            n_step = '0;
            n_x    = CORDIC_K;
            n_y    = '0;
            n_z    = signed'({{(CORDIC_W-32){w_a2[31]}}, w_a2});
        end else if (r_busy) begin
            if (!r_z[CORDIC_W-1]) begin
                n_x = r_x - w_ys;
                n_y = r_y + w_xs;
                n_z = r_z - w_atan;
            end else begin
                n_x = r_x + w_ys;
                n_y = r_y - w_xs;
                n_z = r_z + w_atan;
            end
            n_step = r_step + 1'b1;
            if (r_step == STEP_W'(CORDIC_STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_flip <= n_flip;
        r_step <= n_step;
        r_x    <= n_x;
        r_y    <= n_y;
        r_z    <= n_z;
    end

    assign o_done = r_done;
    assign o_cos  = r_flip ? -r_x : r_x;
    assign o_sin  = r_flip ? -r_y : r_y;

endmodule

### sv/obve_mul.sv
// ----------------------------------------------------------------------------
// obve_mul: serial shift-add multiplier
// One multiplier bit per cycle, unsigned operands.
// ----------------------------------------------------------------------------
module obve_mul
    import obve_pkg::*;
#(
    parameter int A_W = MUL_A_W,
    parameter int B_W = MUL_B_W
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [A_W-1:0]     i_a,
    input  logic [B_W-1:0]     i_b,
    output logic               o_done,
    output logic [A_W+B_W-1:0] o_prod
);

    localparam int P_W   = A_W + B_W;
    localparam int CNT_W = $clog2(B_W);

    logic             r_busy, n_busy, r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [P_W-1:0]   r_acc, n_acc, r_a, n_a;
    logic [B_W-1:0]   r_b, n_b;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        n_a    = r_a;
        n_b    = r_b;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_acc  = '0;
            n_a    = {{B_W{1'b0}}, i_a};
            n_b    = i_b;
        end else if (r_busy) begin
            if (r_b[0]) begin
                n_acc = r_acc + r_a;
            end
            n_a   = {r_a[P_W-2:0], 1'b0};
            n_b   = {1'b0, r_b[B_W-1:1]};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(B_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_acc <= n_acc;
        r_a   <= n_a;
        r_b   <= n_b;
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

### sv/obve_div.sv
// ----------------------------------------------------------------------------
// obve_div: restoring radix-2 divider
// One quotient bit per cycle, unsigned operands, quotient in the shift register.
// ----------------------------------------------------------------------------
module obve_div
    import obve_pkg::*;
#(
    parameter int N_W = NUM_W,
    parameter int D_W = DEN_W
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [N_W-1:0] i_num,
    input  logic [D_W-1:0] i_den,
    output logic           o_done,
    output logic [N_W-1:0] o_quo
);

    localparam int CNT_W = $clog2(N_W);

    logic             r_busy, n_busy, r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [N_W-1:0]   r_num, n_num;
    logic [D_W-1:0]   r_rem, n_rem, r_den, n_den;
    logic [D_W:0]     w_trial, w_diff;

    always_comb begin
        w_trial = {r_rem, r_num[N_W-1]};
        w_diff  = w_trial - {1'b0, r_den};
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_num   = r_num;
        n_rem   = r_rem;
        n_den   = r_den;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_num  = i_num;
            n_rem  = '0;
            n_den  = i_den;
        end else if (r_busy) begin
            if (w_trial >= {1'b0, r_den}) begin
                n_rem = w_diff[D_W-1:0];
                n_num = {r_num[N_W-2:0], 1'b1};
            end else begin
                n_rem = w_trial[D_W-1:0];
                n_num = {r_num[N_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(N_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_num <= n_num;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_done = r_done;
    assign o_quo  = r_num;

endmodule

### tb/odometry_body_velocity_estimator_unit_test.sv
// ----------------------------------------------------------------------------
// odometry_body_velocity_estimator_unit_test: self-checking bench
// Drives pose requests in random bursts with random gaps. It stalls the result
// side on its own pattern, with one long hold-off. It predicts each body-frame
// velocity and yaw rate from its own copy of the stored sample and compares
// every result, field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module odometry_body_velocity_estimator_unit_test;
    import obve_pkg::*;

    // Scoreboard: a private model of the estimator and the queue of results
    // still owed by the block.
    class velocity_scoreboard;
        bit              have_prev;
        logic [47:0]     prev_t;
        logic [31:0]     prev_x, prev_y;
        logic [15:0]     prev_h;
        t_result         owed_q[$];
        int              mismatches;
        longint          atan_q30[24];

        function new();
            atan_q30 = '{64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
                         64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
                         64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
                         64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D,
                         64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
                         64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051};
            have_prev  = 0;
            mismatches = 0;
        endfunction

        // Clamp a sign and magnitude into signed 32 bits.
        function logic [31:0] clamp32(bit neg, logic [127:0] mag);
            if (neg)
                return (mag >= 128'h8000_0000) ? 32'h8000_0000 : -mag[31:0];
            return (mag > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
        endfunction

        // Product with a Q2.30 factor, truncated toward zero.
        function longint mul_q30(longint a, longint c);
            logic [127:0] ua, uc, p;
            ua = (a < 0) ? -a : a;
            uc = (c < 0) ? -c : c;
            p  = (ua * uc) >> 30;
            return ((a < 0) != (c < 0)) ? -longint'(p[63:0]) : longint'(p[63:0]);
        endfunction

        // Position step over time step in Q16.16 per second.
        function logic [31:0] per_second(longint f, logic [47:0] dt);
            logic [127:0] mag;
            mag = (f < 0) ? -f : f;
            mag = mag * 128'd1000000 / dt;
            return clamp32(f < 0, mag);
        endfunction

        // Sine and cosine in Q2.30 from the binary-angle heading.
        function void sin_cos(logic [15:0] h, output longint c, output longint s);
            logic [31:0] a, t;
            bit          flip;
            longint      x, y, z, xs, ys;
            a    = {h, 16'h0};
            t    = a + 32'h4000_0000;
            flip = t[31];
            if (flip)
                a = a ^ 32'h8000_0000;
            z = longint'($signed(a));
            x = 64'h26DD3B6A;
            y = 0;
            for (int i = 0; i < 24; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (z >= 0) begin
                    x = x - ys; y = y + xs; z = z - atan_q30[i];
                end else begin
                    x = x + ys; y = y - xs; z = z + atan_q30[i];
                end
            end
            c = flip ? -x : x;
            s = flip ? -y : y;
        endfunction

        // Note an accepted request; queue the result it is owed, if any.
        function void note_sample(t_sample smp);
            logic [47:0]  dt;
            longint       dx, dy, c, s, fx, fy;
            logic [15:0]  dh;
            logic [127:0] ymag;
            t_result      r;
            if (!have_prev) begin
                have_prev = 1;
                prev_t = smp.sample_time_us; prev_x = smp.position_x;
                prev_y = smp.position_y;     prev_h = smp.heading;
                return;
            end
            // Drop requests whose time does not advance.
            if (smp.sample_time_us <= prev_t)
                return;
            dt = smp.sample_time_us - prev_t;
            dx = longint'($signed(smp.position_x)) - longint'($signed(prev_x));
            dy = longint'($signed(smp.position_y)) - longint'($signed(prev_y));
            sin_cos(smp.heading, c, s);
            fx = mul_q30(dx, c) + mul_q30(dy, s);
            fy = mul_q30(dy, c) - mul_q30(dx, s);
            dh = smp.heading - prev_h;
            ymag = dh[15] ? 128'(-$signed({1'b1, dh})) : 128'(dh);
            ymag = ((ymag * 128'd6283185 * 128'd65536) / dt) >> 16;
            r.vel_x    = per_second(fx, dt);
            r.vel_y    = per_second(fy, dt);
            r.yaw_rate = clamp32(dh[15], ymag);
            owed_q.push_back(r);
            prev_t = smp.sample_time_us; prev_x = smp.position_x;
            prev_y = smp.position_y;     prev_h = smp.heading;
        endfunction

        function void report(string field, logic [31:0] exp_v, logic [31:0] act_v);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: expected %h, got %h", field, exp_v, act_v);
        endfunction

        // Check a result against the oldest owed one.
        function void check_result(t_result got);
            t_result want;
            if (owed_q.size() == 0) begin
                report("unowed result", 32'h0, got.vel_x);
                return;
            end
            want = owed_q.pop_front();
            if (got.vel_x !== want.vel_x)       report("vel_x", want.vel_x, got.vel_x);
            if (got.vel_y !== want.vel_y)       report("vel_y", want.vel_y, got.vel_y);
            if (got.yaw_rate !== want.yaw_rate) report("yaw_rate", want.yaw_rate, got.yaw_rate);
        endfunction
    endclass

    logic    i_clk;
    logic    i_rst_n;
    logic    i_in_valid;
    logic    o_in_stall;
    t_sample i_in;
    logic    o_out_valid;
    logic    i_out_stall;
    t_result o_out;

    velocity_scoreboard board;
    bit          long_hold;
    logic [47:0] cur_t;
    logic [31:0] cur_x, cur_y;
    logic [15:0] cur_h;
    int          burst_left;

    odometry_body_velocity_estimator_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard limit: far beyond the slowest correct run (about 450 requests, plus
    // gaps, stalls and the long hold-off).
    initial begin
        #20_000_000;
        $display("** odometry_body_velocity_estimator_unit: FAILED **");
        $finish;
    end

    // Offer one request and hold it steady until the block takes it. Between
    // bursts, drop valid for a random gap.
    task automatic send_request(input t_sample smp);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 30);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
        i_in       <= smp;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        board.note_sample(smp);
        burst_left--;
        @(negedge i_clk);
    endtask

    task automatic send_pose(input logic [47:0] t, input logic [31:0] x,
                             input logic [31:0] y, input logic [15:0] h);
        t_sample smp;
        smp.sample_time_us = t;
        smp.position_x     = x;
        smp.position_y     = y;
        smp.heading        = h;
        send_request(smp);
    endtask

    // Random signed offset in [-lim, lim].
    function automatic logic [31:0] jitter(int unsigned lim);
        return $urandom_range(0, 2 * lim) - lim;
    endfunction

    // Receiver: alternate runs of stalling and accepting, with some stretches
    // of no stall at all; the long hold-off overrides everything.
    initial begin
        int run;
        int mode;
        i_out_stall = 1'b1;
        @(posedge i_rst_n);
        forever begin
            mode = $urandom_range(0, 3);
            run  = $urandom_range(1, (mode == 0) ? 200 : 25);
            repeat (run) begin
                @(negedge i_clk);
                if (long_hold)
                    i_out_stall <= 1'b1;
                else if (mode == 0)
                    i_out_stall <= 1'b0;
                else
                    i_out_stall <= ($urandom_range(0, mode) != 0);
            end
        end
    end

    // Take results as they are accepted.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            board.check_result(o_out);
    end

    // Long hold-off partway in: the block fills and must stall its input.
    initial begin
        long_hold = 1'b0;
        @(posedge i_rst_n);
        repeat (20_000) @(posedge i_clk);
        long_hold = 1'b1;
        repeat (4_000) @(posedge i_clk);
        long_hold = 1'b0;
    end

    initial begin
        int unsigned pick;
        logic [15:0] heads[8];
        board      = new();
        burst_left = 0;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in       = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: first sample, stale time, extremes, turns and saturation.
        send_pose(48'd0, 32'h0, 32'h0, 16'h0);
        send_pose(48'd0, 32'h1234_5678, 32'h0, 16'h1);
        send_pose(48'd1000, 32'h7FFF_FFFF, 32'h8000_0000, 16'h4000);
        send_pose(48'd1001, 32'h8000_0000, 32'h7FFF_FFFF, 16'hC000);
        send_pose(48'd500, 32'h0, 32'h0, 16'h0);
        send_pose(48'd1001, 32'h0, 32'h0, 16'h0);
        send_pose(48'd2001, 32'h0001_0000, 32'hFFFF_0000, 16'h4000);
        send_pose(48'd2002, 32'h0001_0000, 32'hFFFF_0000, 16'hFFFF);
        heads = '{16'h0000, 16'h8000, 16'h7FFF, 16'h3FFF,
                  16'hBFFF, 16'hC001, 16'h0001, 16'h4001};
        cur_t = 48'd2002;
        cur_x = 32'h0;
        cur_y = 32'h0;
        foreach (heads[k]) begin
            cur_t = cur_t + 48'd20000;
            cur_x = cur_x + 32'h0003_0000;
            cur_y = cur_y - 32'h0001_8000;
            send_pose(cur_t, cur_x, cur_y, heads[k]);
        end
        cur_h = 16'h4001;

        // Random: mostly a smooth trajectory, with stale times, pose jumps and
        // very long or very short time steps mixed in.
        repeat (430) begin
            pick = $urandom_range(0, 99);
            if (pick < 6) begin
                send_pose(cur_t - 48'($urandom_range(0, 5000)), $urandom, $urandom,
                          16'($urandom));
            end else begin
                if (pick < 12)
                    cur_t = cur_t + 48'({8'($urandom_range(0, 255)),
                                         $urandom_range(1, 32'hFFFF_FFFF)});
                else if (pick < 18)
                    cur_t = cur_t + 48'($urandom_range(1, 3));
                else
                    cur_t = cur_t + 48'($urandom_range(1000, 200000));
                if (pick >= 90) begin
                    cur_x = $urandom;
                    cur_y = $urandom;
                    cur_h = 16'($urandom);
                end else begin
                    cur_x = cur_x + jitter(400000);
                    cur_y = cur_y + jitter(400000);
                    cur_h = cur_h + 16'(jitter(3000));
                end
                send_pose(cur_t, cur_x, cur_y, cur_h);
            end
        end

        // Close on the latest possible timestamp.
        send_pose(48'hFFFF_FFFF_FFFF, ~cur_x, ~cur_y, ~cur_h);
        i_in_valid <= 1'b0;

        while (board.owed_q.size() != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
        if (board.mismatches == 0)
            $display("** odometry_body_velocity_estimator_unit: PASSED **");
        else
            $display("** odometry_body_velocity_estimator_unit: FAILED **");
        $finish;
    end

endmodule
